@@ design/dbvs_pkg.sv @@
// Shared types and constants for the depth-budget visited set.
// No dependencies; used by depth_budget_visited_set_top.
`default_nettype none

package dbvs_pkg;

  localparam int TABLE_SIZE_DEF = 64;

  localparam int HASH_W  = 32;
  localparam int DEPTH_W = 8;
  localparam int LIMIT_W = 7;
  localparam int COUNT_W = 7;

  localparam logic [LIMIT_W-1:0] START_DEPTH_RST = 7'd12;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // One table entry, stored as a single memory word.
  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [DEPTH_W-1:0] least;
    logic [DEPTH_W-1:0] budget;
  } entry_t;

endpackage

`default_nettype wire

@@ design/depth_budget_visited_set_top.sv @@
// Depth-budget visited set: top level with control sequencer and entry memory.
// Depends on dbvs_pkg and dbvs_ram.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready. in_tuser carries the command
//   (add or clear); in_tdata carries the hash (bits 31:0) and depth (39:32).
//   Every input word yields exactly one result word on out_tvalid/out_tready:
//   accepted flag, current depth limit and entry count after the operation.
//   The start depth is loaded through cfg_wr_en/cfg_wr_data; it takes effect
//   at the next clear.
// Operation:
//   A clear, or an add refused on depth, gives its result in the cycle after
//   acceptance. An add with room in the table searches the sorted table
//   through the single read port until it meets an equal or larger hash and,
//   on insertion in the middle, moves the upper entries up by one place. An
//   add on a full table first runs a maximum pass and a compaction pass over
//   all TABLE_SIZE entries. The memory's one read and one write port set the
//   pace of these passes; a new word is taken only when the block is idle.
// Reset:
//   The table is empty, the limit and start depth are 12. Memory contents
//   are not cleared; only entries below the count are ever read.
// Back-pressure:
//   The result is held in an output register; a new word is taken only once
//   that register is free or being emptied in the same cycle.
`default_nettype none

module depth_budget_visited_set_top #(
  parameter int TABLE_SIZE = dbvs_pkg::TABLE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: start_max_depth
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] hash, [39:32] depth
  input  wire logic        in_tuser,   // [0] command
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [0] accepted, [7:1] depth_limit,
                                       // [14:8] entry_count, [15] zero
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int EW = $bits(dbvs_pkg::entry_t);
  localparam logic [CW-1:0] FULL = CW'(TABLE_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_COMPACT,
    S_SEARCH,
    S_SHIFT
  } state_t;

  // control state
  state_t                              state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [dbvs_pkg::LIMIT_W-1:0]        limit_r, limit_nxt;
  logic [dbvs_pkg::LIMIT_W-1:0]        start_r;
  logic [CW-1:0]                       ra_r, ra_nxt;     // read pointer
  logic                                rv_r, rv_nxt;     // read data valid
  logic [IW-1:0]                       pa_r, pa_nxt;     // address of read data
  logic [CW-1:0]                       wa_r, wa_nxt;     // compaction write pointer
  logic [IW-1:0]                       ins_r, ins_nxt;   // insertion slot
  logic                                sh_issue_r, sh_issue_nxt;
  logic [dbvs_pkg::DEPTH_W-1:0]        top_r, top_nxt;   // largest stored depth
  logic                                out_valid_r, out_valid_nxt;
  logic                                acc_r, acc_nxt;

  // payload of the word in progress
  logic [dbvs_pkg::HASH_W-1:0]         h_r;
  logic [dbvs_pkg::DEPTH_W-1:0]        d_r;

  // memory port
  logic                                ram_we;
  logic [IW-1:0]                       ram_waddr;
  logic [IW-1:0]                       ram_raddr;
  dbvs_pkg::entry_t                    ram_wdata;
  dbvs_pkg::entry_t                    rd;
  logic [EW-1:0]                       rd_bits;

  logic                                in_acc;
  logic [dbvs_pkg::HASH_W-1:0]         in_hash;
  logic [dbvs_pkg::DEPTH_W-1:0]        in_depth;
  logic [dbvs_pkg::DEPTH_W-1:0]        limit_ext;
  logic [dbvs_pkg::DEPTH_W-1:0]        budget;
  logic [dbvs_pkg::LIMIT_W-1:0]        shrunk_limit;
  dbvs_pkg::entry_t                    new_entry;
  logic                                issue;
  logic                                stop;
  logic [CW+6:0]                       count_ext;

  dbvs_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  assign rd        = dbvs_pkg::entry_t'(rd_bits);
  assign in_hash   = in_tdata[31:0];
  assign in_depth  = in_tdata[39:32];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign limit_ext = {1'b0, limit_r};
  assign budget    = limit_ext - d_r;

  assign new_entry.hash   = h_r;
  assign new_entry.least  = d_r;
  assign new_entry.budget = budget;

  // Limit after a full-table shrink: largest depth minus one, floor at zero,
  // saturated to the limit width.
  always_comb begin
    if (top_r == '0) begin
      shrunk_limit = '0;
    end else if (top_r > 8'd128) begin
      shrunk_limit = '1;
    end else begin
      shrunk_limit = dbvs_pkg::LIMIT_W'(top_r - 8'd1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    ra_nxt        = ra_r;
    rv_nxt        = 1'b0;
    pa_nxt        = pa_r;
    wa_nxt        = wa_r;
    ins_nxt       = ins_r;
    sh_issue_nxt  = sh_issue_r;
    top_nxt       = top_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = new_entry;
    ram_raddr     = ra_r[IW-1:0];
    issue         = 1'b0;
    stop          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (dbvs_pkg::cmd_t'(in_tuser) == dbvs_pkg::CMD_CLEAR) begin
            count_nxt     = '0;
            limit_nxt     = start_r;
            acc_nxt       = 1'b0;
            out_valid_nxt = 1'b1;
          end else if (in_depth > limit_ext) begin
            acc_nxt       = 1'b0;
            out_valid_nxt = 1'b1;
          end else if (count_r >= FULL) begin
            ra_nxt    = '0;
            top_nxt   = '0;
            state_nxt = S_MAX;
          end else begin
            ra_nxt    = '0;
            state_nxt = S_SEARCH;
          end
        end
      end

      S_MAX: begin
        issue = ra_r < count_r;
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
          rv_nxt = 1'b1;
        end
        if (rv_r && (rd.least > top_r)) begin
          top_nxt = rd.least;
        end
        if (!issue && !rv_r) begin
          limit_nxt = shrunk_limit;
          ra_nxt    = '0;
          wa_nxt    = '0;
          state_nxt = S_COMPACT;
        end
      end

      S_COMPACT: begin
        issue = ra_r < count_r;
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
          rv_nxt = 1'b1;
        end
        // keep entries within the new limit, packed downwards in order
        if (rv_r && (rd.least <= limit_ext)) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r[IW-1:0];
          ram_wdata = rd;
          wa_nxt    = wa_r + 1'b1;
        end
        if (!issue && !rv_r) begin
          count_nxt = wa_r;
          if ((wa_r >= FULL) || (d_r > limit_ext)) begin
            acc_nxt       = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ra_nxt    = '0;
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        stop  = rv_r && (rd.hash >= h_r);
        issue = (ra_r < count_r) && !stop;
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
          rv_nxt = 1'b1;
          pa_nxt = ra_r[IW-1:0];
        end
        if (rv_r && (rd.hash == h_r)) begin
          // known hash: lower its depth, raise its budget if better
          ram_we           = 1'b1;
          ram_waddr        = pa_r;
          ram_wdata.hash   = h_r;
          ram_wdata.least  = (rd.least > d_r) ? d_r : rd.least;
          ram_wdata.budget = (rd.budget >= budget) ? rd.budget : budget;
          acc_nxt          = rd.budget < budget;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else if (stop) begin
          // larger hash found: open a slot here
          ins_nxt      = pa_r;
          ra_nxt       = count_r - 1'b1;
          sh_issue_nxt = 1'b1;
          state_nxt    = S_SHIFT;
        end else if (!issue && !rv_r) begin
          // append at the end
          ram_we        = 1'b1;
          ram_waddr     = count_r[IW-1:0];
          count_nxt     = count_r + 1'b1;
          acc_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SHIFT: begin
        // read from the top down, write each entry one place higher
        if (sh_issue_r) begin
          rv_nxt = 1'b1;
          pa_nxt = ra_r[IW-1:0];
          if (ra_r[IW-1:0] == ins_r) begin
            sh_issue_nxt = 1'b0;
          end else begin
            ra_nxt = ra_r - 1'b1;
          end
        end
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pa_r + 1'b1);
          ram_wdata = rd;
        end else if (!sh_issue_r) begin
          ram_we        = 1'b1;
          ram_waddr     = ins_r;
          count_nxt     = count_r + 1'b1;
          acc_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= dbvs_pkg::START_DEPTH_RST;
      start_r     <= dbvs_pkg::START_DEPTH_RST;
      ra_r        <= '0;
      rv_r        <= 1'b0;
      wa_r        <= '0;
      sh_issue_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      ra_r        <= ra_nxt;
      rv_r        <= rv_nxt;
      wa_r        <= wa_nxt;
      sh_issue_r  <= sh_issue_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
    end
  end

  // payload and pointers that need no reset
  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    ins_r <= ins_nxt;
    top_r <= top_nxt;
    if (in_acc) begin
      h_r <= in_hash;
      d_r <= in_depth;
    end
  end

  // Limit and count only change on the next accepted word, which needs the
  // output register free, so they can feed the result directly.
  assign count_ext  = {7'd0, count_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, count_ext[6:0], limit_r, acc_r};

endmodule

`default_nettype wire

@@ design/dbvs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dbvs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
